### hdl/mrst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrst_pkg
// Shared types and command codes for the multi-rule substring trigger.
// ----------------------------------------------------------------------------
package mrst_pkg;

    typedef enum logic [2:0] {
        CMD_BYTE   = 3'd0,
        CMD_EOL    = 3'd1,
        CMD_STAGE  = 3'd2,
        CMD_APPEND = 3'd3,
        CMD_REMOVE = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_IDX  = 2'd2;

    localparam int TIME_W = 48;
    localparam int CD_W   = 31;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data;
        logic [47:0] now_ms;
        logic [3:0]  rule_index;
        logic [4:0]  byte_position;
        logic [4:0]  pattern_length;
        logic        ignore_case;
        logic        rule_on;
        logic [30:0] cooldown;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] fired_count;
        logic [7:0] fired_mask;
        logic [2:0] rule_slot;
    } out_item_t;

    // Control to each rule cell
    typedef struct packed {
        logic        shift_byte;
        logic        eol;
        logic        append_here;
        logic        shift_down;
        logic [47:0] now_ms;
    } cell_ctl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold);
        if (fold && c >= 8'h41 && c <= 8'h5A)
            return c + 8'd32;
        return c;
    endfunction

endpackage

### hdl/mrst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrst_in_if / mrst_out_if
// Valid/ready channels for the trigger's input and result transactions.
// ----------------------------------------------------------------------------
interface mrst_in_if;
    logic valid;
    logic ready;
    mrst_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mrst_out_if;
    logic valid;
    logic ready;
    mrst_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/multi_rule_substring_trigger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_rule_substring_trigger
// Table of substring rules matched against a shifting line window.
// ----------------------------------------------------------------------------
// The rule cells compare against the byte window in parallel, and end of
// line, append and remove resolve in the cycle they are taken. A new
// transaction is accepted each cycle while the result register is empty or
// being drained; end of line, append and remove return one result, line and
// staging bytes return none.
module multi_rule_substring_trigger #(
    parameter int NUM_RULES = 8,
    parameter int PAT_LEN   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    mrst_in_if.sink     in_ch,
    mrst_out_if.source  out_ch
);
    localparam int LW = $clog2(PAT_LEN);
    localparam int FW = $clog2(PAT_LEN+1);
    localparam int TW = $clog2(NUM_RULES+1);

    // Byte window (newest at index 0) and its fill
    logic [PAT_LEN-1:0][7:0] win_reg, win_next;
    logic [FW-1:0]           fill_reg;
    logic [PAT_LEN-1:0][7:0] stage_reg;
    logic [TW-1:0]           total_reg;

    mrst_pkg::out_item_t res_reg, res_next;
    logic                res_valid_reg;

    logic take;
    logic res_load;
    mrst_pkg::in_item_t it;
    logic [2:0] cmd;

    assign it  = in_ch.payload;
    assign cmd = it.cmd;
    assign in_ch.ready = !res_valid_reg || out_ch.ready;
    assign take = in_ch.valid && in_ch.ready;
    // end of line, append and remove each return one result transaction
    assign res_load = take && (cmd inside {mrst_pkg::CMD_EOL, mrst_pkg::CMD_APPEND,
                                           mrst_pkg::CMD_REMOVE});

    logic full;
    logic bad_idx;
    assign full    = (total_reg >= TW'(NUM_RULES));
    assign bad_idx = (32'(it.rule_index) >= 32'(total_reg));

    // New pattern: staging bytes up to the saturated length, rest zero
    logic [LW-1:0] new_len;
    logic [PAT_LEN-1:0][7:0] new_pat;
    always_comb
    begin
        if (32'(it.pattern_length) > PAT_LEN - 1)
            new_len = LW'(PAT_LEN - 1);
        else
            new_len = LW'(it.pattern_length);
        for (int k = 0; k < PAT_LEN; k++)
            new_pat[k] = (k < int'(new_len)) ? stage_reg[k] : 8'd0;
        win_next = {win_reg[PAT_LEN-2:0], it.data} ;
    end

    // Cell chain wiring
    logic [NUM_RULES:0][PAT_LEN-1:0][7:0] c_pat;
    logic [NUM_RULES:0][LW-1:0] c_len;
    logic [NUM_RULES:0]         c_on, c_fold, c_match;
    logic [NUM_RULES:0][30:0]   c_cd;
    logic [NUM_RULES:0][47:0]   c_last;
    logic [NUM_RULES-1:0]       c_fire;

    assign c_pat[NUM_RULES]   = '0;
    assign c_len[NUM_RULES]   = '0;
    assign c_on[NUM_RULES]    = 1'b0;
    assign c_fold[NUM_RULES]  = 1'b0;
    assign c_match[NUM_RULES] = 1'b0;
    assign c_cd[NUM_RULES]    = '0;
    assign c_last[NUM_RULES]  = '0;

    // Window as seen by cells: after this byte is shifted in
    logic [PAT_LEN-1:0][7:0] cell_win;
    logic [FW-1:0]           cell_fill;
    always_comb
    begin
        for (int k = 0; k < PAT_LEN; k++)
            cell_win[k] = win_next[PAT_LEN-1-k];
        cell_fill = (fill_reg < FW'(PAT_LEN)) ? fill_reg + 1'b1 : fill_reg;
    end

    genvar g;
    generate
        for (g = 0; g < NUM_RULES; g++)
        begin : g_cell
            mrst_pkg::cell_ctl_t ctl;
            always_comb
            begin
                ctl.shift_byte  = take && cmd == mrst_pkg::CMD_BYTE;
                ctl.eol         = take && cmd == mrst_pkg::CMD_EOL;
                ctl.append_here = take && cmd == mrst_pkg::CMD_APPEND && !full
                                  && total_reg == TW'(g);
                ctl.shift_down  = take && cmd == mrst_pkg::CMD_REMOVE && !bad_idx
                                  && 32'(it.rule_index) <= g;
                ctl.now_ms      = it.now_ms;
            end
            mrst_cell #(.PAT_LEN(PAT_LEN)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl),
                .active(TW'(g) < total_reg),
                .window(cell_win), .fill(cell_fill),
                .new_pat(new_pat), .new_len(new_len), .new_on(it.rule_on),
                .new_fold(it.ignore_case), .new_cd(it.cooldown),
                .up_pat(c_pat[g+1]), .up_len(c_len[g+1]), .up_on(c_on[g+1]),
                .up_fold(c_fold[g+1]), .up_cd(c_cd[g+1]), .up_last(c_last[g+1]),
                .up_match(c_match[g+1]),
                .pat(c_pat[g]), .len(c_len[g]), .on(c_on[g]), .fold(c_fold[g]),
                .cd(c_cd[g]), .last(c_last[g]), .match(c_match[g]), .fire(c_fire[g])
            );
        end
    endgenerate

    // Result of the transaction on the input this cycle
    always_comb
    begin
        res_next = '0;
        case (cmd)
            mrst_pkg::CMD_EOL:
            begin
                res_next.fired_count = 4'($countones(c_fire));
                for (int i = 0; i < 8 && i < NUM_RULES; i++)
                    res_next.fired_mask[i] = c_fire[i];
            end
            mrst_pkg::CMD_APPEND:
            begin
                if (full)
                    res_next.status = mrst_pkg::ST_FULL;
                else
                    res_next.rule_slot = 3'(total_reg);
            end
            mrst_pkg::CMD_REMOVE:
            begin
                if (bad_idx)
                    res_next.status = mrst_pkg::ST_BAD_IDX;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            fill_reg      <= '0;
            stage_reg     <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_load)
            begin
                res_reg       <= res_next;
                res_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                res_valid_reg <= 1'b0;
            if (take)
            begin
                case (cmd)
                    mrst_pkg::CMD_BYTE:
                    begin
                        win_reg  <= win_next;
                        fill_reg <= cell_fill;
                    end
                    mrst_pkg::CMD_EOL:
                    begin
                        win_reg  <= '0;
                        fill_reg <= '0;
                    end
                    mrst_pkg::CMD_STAGE:
                    begin
                        if (32'(it.byte_position) < PAT_LEN)
                            stage_reg[LW'(it.byte_position)] <= it.data;
                    end
                    mrst_pkg::CMD_APPEND:
                    begin
                        if (!full)
                            total_reg <= total_reg + 1'b1;
                    end
                    mrst_pkg::CMD_REMOVE:
                    begin
                        if (!bad_idx)
                            total_reg <= total_reg - 1'b1;
                    end
                    default:
                    begin
                        fill_reg <= fill_reg;
                    end
                endcase
            end
        end
    end

    assign out_ch.valid   = res_valid_reg;
    assign out_ch.payload = res_reg;
endmodule

### hdl/mrst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrst_cell
// One rule slot: pattern, flags, cooldown, last fire time and match mark.
// ----------------------------------------------------------------------------
module mrst_cell #(
    parameter int PAT_LEN = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mrst_pkg::cell_ctl_t     ctl,
    input  logic                    active,
    input  logic [PAT_LEN-1:0][7:0] window,
    input  logic [$clog2(PAT_LEN+1)-1:0] fill,
    // new rule contents
    input  logic [PAT_LEN-1:0][7:0] new_pat,
    input  logic [$clog2(PAT_LEN)-1:0] new_len,
    input  logic                    new_on,
    input  logic                    new_fold,
    input  logic [30:0]             new_cd,
    // neighbour above, for shift-down on remove
    input  logic [PAT_LEN-1:0][7:0] up_pat,
    input  logic [$clog2(PAT_LEN)-1:0] up_len,
    input  logic                    up_on,
    input  logic                    up_fold,
    input  logic [30:0]             up_cd,
    input  logic [47:0]             up_last,
    input  logic                    up_match,
    output logic [PAT_LEN-1:0][7:0] pat,
    output logic [$clog2(PAT_LEN)-1:0] len,
    output logic                    on,
    output logic                    fold,
    output logic [30:0]             cd,
    output logic [47:0]             last,
    output logic                    match,
    output logic                    fire
);
    localparam int LW = $clog2(PAT_LEN);
    localparam int FW = $clog2(PAT_LEN+1);

    logic [PAT_LEN-1:0][7:0] pat_reg;
    logic [LW-1:0]  len_reg;
    logic           on_reg, fold_reg, match_reg;
    logic [30:0]    cd_reg;
    logic [47:0]    last_reg;

    logic           tail_hit;
    logic           cooling;
    logic [PAT_LEN-1:0] eq;

    // Window with newest byte at top; pattern byte k aligns with
    // window[PAT_LEN - len + k], after this cycle's byte is shifted in.
    always_comb
    begin
        for (int k = 0; k < PAT_LEN; k++)
        begin
            if (k < int'(len_reg))
                eq[k] = mrst_pkg::fold_byte(window[PAT_LEN - int'(len_reg) + k], fold_reg)
                        == mrst_pkg::fold_byte(pat_reg[k], fold_reg);
            else
                eq[k] = 1'b1;
        end
        tail_hit = (len_reg != '0) && (FW'(len_reg) <= fill) && (&eq);
        cooling = 1'b0;
        if (cd_reg != '0 && last_reg != '0)
            cooling = (ctl.now_ms < last_reg) ||
                      ((ctl.now_ms - last_reg) < {17'd0, cd_reg});
        fire = active && on_reg && (match_reg || len_reg == '0) && !cooling;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg   <= '0;
            len_reg   <= '0;
            on_reg    <= 1'b0;
            fold_reg  <= 1'b0;
            cd_reg    <= '0;
            last_reg  <= '0;
            match_reg <= 1'b0;
        end
        else if (ctl.append_here)
        begin
            pat_reg   <= new_pat;
            len_reg   <= new_len;
            on_reg    <= new_on;
            fold_reg  <= new_fold;
            cd_reg    <= new_cd;
            last_reg  <= '0;
            match_reg <= 1'b0;
        end
        else if (ctl.shift_down)
        begin
            pat_reg   <= up_pat;
            len_reg   <= up_len;
            on_reg    <= up_on;
            fold_reg  <= up_fold;
            cd_reg    <= up_cd;
            last_reg  <= up_last;
            match_reg <= up_match;
        end
        else if (ctl.eol)
        begin
            if (fire)
                last_reg <= ctl.now_ms;
            match_reg <= 1'b0;
        end
        else if (ctl.shift_byte && active && tail_hit)
        begin
            match_reg <= 1'b1;
        end
    end

    assign pat   = pat_reg;
    assign len   = len_reg;
    assign on    = on_reg;
    assign fold  = fold_reg;
    assign cd    = cd_reg;
    assign last  = last_reg;
    assign match = match_reg;
endmodule

### hdl/mrst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrst_checker
// Port-level checks on the trigger's channels.
// ----------------------------------------------------------------------------
module mrst_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input mrst_pkg::out_item_t out_payload
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_payload.status != 2'd3)
        else $error("bad status");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_payload.fired_count) == $countones(out_payload.fired_mask))
        else $error("count disagrees with mask");
endmodule

bind multi_rule_substring_trigger mrst_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_payload(out_ch.payload)
);

### tb/multi_rule_substring_trigger_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_rule_substring_trigger_test
// Self-checking bench for the substring trigger: a directed phase per
// behaviour, then constrained-by-hand random traffic of rule edits and lines.
// A local predictor mirrors the rule table, line window and firing times;
// every result transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module multi_rule_substring_trigger_test;

    localparam int RULES = 8;
    localparam int WIN   = 32;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam logic [3:0][7:0] LETTERS = "aAbB";

    logic clk;
    logic rst_n;

    mrst_in_if  in_ch ();
    mrst_out_if out_ch ();

    multi_rule_substring_trigger #(.NUM_RULES(RULES), .PAT_LEN(WIN)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the rule table and the line window
    // ------------------------------------------------------------------
    logic [7:0]      stage_buf [WIN];
    logic [7:0]      rule_pat  [RULES][WIN];
    logic [4:0]      rule_len  [RULES];
    logic            rule_en   [RULES];
    logic            rule_ci   [RULES];
    logic [mrst_pkg::CD_W-1:0] rule_cd   [RULES];
    logic [mrst_pkg::TIME_W-1:0] rule_last [RULES];
    logic            rule_hit  [RULES];
    logic [7:0]      line_win  [WIN];
    int              rules_held;
    int              win_fill;

    mrst_pkg::out_item_t pending_results [$];

    // Stimulus knobs shared with the response side
    logic [mrst_pkg::TIME_W-1:0] clock_ms;
    int  send_gap_pct;
    int  drain_gap_pct;
    int  hold_off_cycles;
    int  mismatches;
    int  sent_items;

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > TIMEOUT_CYCLES)
            begin
                $display("** multi_rule_substring_trigger: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] to_lower(logic [7:0] c, logic ci);
        return (ci && c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Does rule r's pattern end at the newest byte of the window?
    function automatic logic tail_hit(int r);
        int n;
        n = rule_len[r];
        if (n == 0 || n > win_fill)
            return 1'b0;
        for (int k = 0; k < n; k++)
            if (to_lower(line_win[WIN - n + k], rule_ci[r]) !=
                to_lower(rule_pat[r][k], rule_ci[r]))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_shadow();
        foreach (stage_buf[i]) stage_buf[i] = '0;
        foreach (line_win[i]) line_win[i] = '0;
        for (int r = 0; r < RULES; r++)
        begin
            foreach (rule_pat[r][k]) rule_pat[r][k] = '0;
            rule_len[r] = '0; rule_en[r] = 0; rule_ci[r] = 0;
            rule_cd[r] = '0; rule_last[r] = '0; rule_hit[r] = 0;
        end
        rules_held = 0;
        win_fill   = 0;
    endtask

    // Apply one accepted transaction to the shadow, queue its result if any
    task automatic apply_command(mrst_pkg::in_item_t t);
        mrst_pkg::out_item_t res;
        res = '0;
        case (t.cmd)
            mrst_pkg::CMD_BYTE:
            begin
                for (int i = 0; i < WIN - 1; i++) line_win[i] = line_win[i + 1];
                line_win[WIN - 1] = t.data;
                if (win_fill < WIN) win_fill++;
                for (int r = 0; r < rules_held; r++)
                    if (tail_hit(r)) rule_hit[r] = 1'b1;
            end
            mrst_pkg::CMD_EOL:
            begin
                for (int r = 0; r < rules_held; r++)
                begin
                    logic fire, cooling;
                    fire = rule_hit[r] || rule_len[r] == 0;
                    cooling = 1'b0;
                    // a zero last time is treated as the rule never having fired
                    if (rule_cd[r] != 0 && rule_last[r] != 0)
                        cooling = t.now_ms < rule_last[r] ||
                                  (t.now_ms - rule_last[r]) < {17'd0, rule_cd[r]};
                    if (rule_en[r] && fire && !cooling)
                    begin
                        rule_last[r] = t.now_ms;
                        res.fired_count++;
                        res.fired_mask[r] = 1'b1;
                    end
                end
                foreach (rule_hit[r]) rule_hit[r] = 1'b0;
                foreach (line_win[i]) line_win[i] = '0;
                win_fill = 0;
                pending_results.push_back(res);
            end
            mrst_pkg::CMD_STAGE:
                stage_buf[t.byte_position] = t.data;
            mrst_pkg::CMD_APPEND:
            begin
                if (rules_held >= RULES)
                    res.status = mrst_pkg::ST_FULL;
                else
                begin
                    int r;
                    r = rules_held;
                    for (int k = 0; k < WIN; k++)
                        rule_pat[r][k] = (k < t.pattern_length) ? stage_buf[k] : 8'h00;
                    rule_len[r]  = (t.pattern_length > WIN - 1) ? 5'(WIN - 1)
                                                                : t.pattern_length;
                    rule_en[r]   = t.rule_on;
                    rule_ci[r]   = t.ignore_case;
                    rule_cd[r]   = t.cooldown;
                    rule_last[r] = '0;
                    rule_hit[r]  = 1'b0;
                    rules_held++;
                    res.rule_slot = 3'(r);
                end
                pending_results.push_back(res);
            end
            mrst_pkg::CMD_REMOVE:
            begin
                if (t.rule_index >= rules_held)
                    res.status = mrst_pkg::ST_BAD_IDX;
                else
                begin
                    for (int r = t.rule_index; r + 1 < rules_held; r++)
                    begin
                        rule_pat[r] = rule_pat[r + 1];
                        rule_len[r] = rule_len[r + 1];
                        rule_en[r]  = rule_en[r + 1];
                        rule_ci[r]  = rule_ci[r + 1];
                        rule_cd[r]  = rule_cd[r + 1];
                        rule_last[r] = rule_last[r + 1];
                        rule_hit[r] = rule_hit[r + 1];
                    end
                    rules_held--;
                end
                pending_results.push_back(res);
            end
            default: ;  // codes 5..7 are ignored by the block
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: one transaction, with random idle cycles ahead of it
    // ------------------------------------------------------------------
    task automatic send_txn(logic [2:0] cmd, logic [7:0] data = 8'h00,
                            logic [3:0] idx = '0, logic [4:0] pos = '0,
                            logic [4:0] plen = '0, logic ci = 0, logic on = 1,
                            logic [mrst_pkg::CD_W-1:0] cd = '0);
        mrst_pkg::in_item_t t;
        t.cmd = cmd; t.data = data; t.now_ms = clock_ms; t.rule_index = idx;
        t.byte_position = pos; t.pattern_length = plen; t.ignore_case = ci;
        t.rule_on = on; t.cooldown = cd;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= t;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        apply_command(t);
        sent_items++;
    endtask

    task automatic line_of(string s);
        for (int i = 0; i < s.len(); i++) send_txn(mrst_pkg::CMD_BYTE, s[i]);
    endtask

    task automatic load_rule(string s, logic ci, logic on,
                             logic [mrst_pkg::CD_W-1:0] cd);
        for (int i = 0; i < s.len(); i++) send_txn(mrst_pkg::CMD_STAGE, s[i], 0, 5'(i));
        send_txn(mrst_pkg::CMD_APPEND, 0, 0, 0, 5'(s.len()), ci, on, cd);
    endtask

    task automatic empty_table();
        while (rules_held > 0) send_txn(mrst_pkg::CMD_REMOVE, 0, 4'(rules_held - 1));
    endtask

    // Wait for all outstanding results, then let the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker; also owns out_ch.ready and the long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_check
        mrst_pkg::out_item_t want;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %p", out_ch.payload);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.payload.status != want.status ||
                        out_ch.payload.fired_count != want.fired_count ||
                        out_ch.payload.fired_mask != want.fired_mask ||
                        out_ch.payload.rule_slot != want.rule_slot)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p",
                                     want, out_ch.payload);
                    end
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= drain_gap_pct);
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Empty table, empty line; then an empty-pattern rule fires on any line, and a bad-index remove
    task automatic test_empty_rules();
        send_txn(mrst_pkg::CMD_EOL);
        send_txn(mrst_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 1, 0);
        send_txn(mrst_pkg::CMD_EOL);
        send_txn(mrst_pkg::CMD_REMOVE, 0, 4'd15);           // bad index
        empty_table();
    endtask

    // Case folding, zero bytes, staging edges, unknown codes
    task automatic test_matching();
        send_txn(mrst_pkg::CMD_STAGE, 8'hFF, 0, 5'd31);    // last staging slot
        load_rule("Ab", 1, 1, 0);
        load_rule("Ab", 0, 1, 0);
        send_txn(mrst_pkg::CMD_STAGE, 8'h00, 0, 0);         // zero byte inside a pattern
        send_txn(mrst_pkg::CMD_APPEND, 0, 0, 0, 5'd31, 0, 0, 0);
        send_txn(3'd5, 8'hAA); send_txn(3'd6); send_txn(3'd7);
        line_of("xaB");
        send_txn(mrst_pkg::CMD_BYTE, 8'h00);
        send_txn(mrst_pkg::CMD_EOL);
        empty_table();
    endtask

    // Cooldown: firing at time zero, time stepping back, widest values
    task automatic test_cooldown();
        load_rule("q", 0, 1, 31'h7FFF_FFFF);
        load_rule("q", 0, 1, 31'd10);
        clock_ms = '0;       line_of("q"); send_txn(mrst_pkg::CMD_EOL);
        clock_ms = 48'd5;    line_of("q"); send_txn(mrst_pkg::CMD_EOL);
        clock_ms = 48'd3;    line_of("q"); send_txn(mrst_pkg::CMD_EOL);   // backwards
        clock_ms = 48'd20;   line_of("q"); send_txn(mrst_pkg::CMD_EOL);
        clock_ms = 48'hFFFF_FFFF_FFFF; line_of("q"); send_txn(mrst_pkg::CMD_EOL);
        empty_table();
        clock_ms = 48'd100;
    endtask

    // Table full, then removals from the middle while a line is open
    task automatic test_full_and_shift();
        for (int i = 0; i < RULES; i++)
            send_txn(mrst_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 1, 0);
        send_txn(mrst_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 1, 0);
        line_of("z");
        send_txn(mrst_pkg::CMD_REMOVE, 0, 4'd3);
        send_txn(mrst_pkg::CMD_REMOVE, 0, 4'd7);          // now out of range
        send_txn(mrst_pkg::CMD_EOL);
        empty_table();
    endtask

    // Long receiver stall while the sender keeps offering transactions
    task automatic test_backpressure();
        send_txn(mrst_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 1, 0);
        hold_off_cycles = 300;
        repeat (40) send_txn(mrst_pkg::CMD_EOL);
        empty_table();
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly rule loads and lines built from rule patterns
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_byte();
        int k;
        k = $urandom_range(9);
        if (k < 6 && rules_held > 0)
        begin
            int r;
            r = $urandom_range(rules_held - 1);
            if (rule_len[r] != 0)
            begin
                logic [7:0] c;
                c = rule_pat[r][5'($urandom_range(rule_len[r] - 1))];
                if ($urandom_range(3) == 0 && c >= "a" && c <= "z") c -= 8'd32;
                return c;
            end
        end
        if (k < 9)
            return LETTERS[2'($urandom_range(3))];
        return 8'($urandom);
    endfunction

    task automatic test_random(int count);
        int stop_at;
        stop_at = sent_items + count;
        while (sent_items < stop_at)
        begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 15 && rules_held < RULES)
            begin
                int n;
                n = $urandom_range(4);
                for (int i = 0; i < n; i++)
                    send_txn(mrst_pkg::CMD_STAGE, LETTERS[2'($urandom_range(3))], 0, 5'(i));
                send_txn(mrst_pkg::CMD_APPEND, 0, 0, 0,
                         ($urandom_range(19) == 0) ? 5'($urandom) : 5'(n),
                         1'($urandom), ($urandom_range(4) != 0),
                         ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(40)));
            end
            else if (pick < 22)
                send_txn(mrst_pkg::CMD_REMOVE, 0, ($urandom_range(3) == 0) ? 4'($urandom)
                         : 4'($urandom_range(rules_held > 0 ? rules_held - 1 : 0)));
            else if (pick < 25)
                send_txn(mrst_pkg::CMD_STAGE, 8'($urandom), 0, 5'($urandom));
            else if (pick < 27)
                send_txn(mrst_pkg::CMD_APPEND, 0, 0, 0, 5'($urandom), 1'($urandom),
                         1'($urandom), 31'($urandom));
            else
            begin
                int n;
                n = $urandom_range(12);
                for (int i = 0; i < n; i++) send_txn(mrst_pkg::CMD_BYTE, pick_byte());
                clock_ms += 48'($urandom_range(30));
                send_txn(mrst_pkg::CMD_EOL);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        clock_ms = 48'd100;
        send_gap_pct = 25; drain_gap_pct = 56;
        hold_off_cycles = 0; mismatches = 0; sent_items = 0;
        clear_shadow();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_rules();
        test_matching();
        test_cooldown();
        test_full_and_shift();
        test_backpressure();

        test_random(450);
        send_gap_pct = 56; drain_gap_pct = 25;
        test_random(450);
        send_gap_pct = 0; drain_gap_pct = 0;
        test_random(450);

        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** multi_rule_substring_trigger: PASSED **");
        else
            $display("** multi_rule_substring_trigger: FAILED **");
        $finish;
    end

endmodule

### multi_rule_substring_trigger.f
hdl/mrst_pkg.sv
hdl/mrst_if.sv
hdl/mrst_cell.sv
hdl/multi_rule_substring_trigger.sv
hdl/mrst_checker.sv
tb/multi_rule_substring_trigger_test.sv
